// ===== sv/sfbp_pkg.sv =====
// sfbp_pkg: shared types, constants and width schedule for the speech frame bit packer.
// No dependencies.
package sfbp_pkg;

  localparam int unsigned FRAME_PARAMS = 76;
  localparam int unsigned LAR_COUNT    = 8;
  localparam int unsigned SUBSEG_LEN   = 17;
  localparam int unsigned BYTE_BITS    = 8;

  localparam logic [6:0] LAST_PARAM_IDX = 7'(FRAME_PARAMS - 1);
  localparam logic [4:0] LAST_SUB_IDX   = 5'(SUBSEG_LEN - 1);
  localparam logic [2:0] PULSE_WIDTH    = 3'd3;
  localparam logic [3:0] FULL_BYTE_BITS = 4'(BYTE_BITS);

  // packer state carried between words
  typedef struct packed {
    logic [7:0] acc;   // pending bits, upper bits zero
    logic [2:0] pos;   // number of pending bits
    logic [6:0] fc;    // parameter index in frame
    logic [4:0] sub;   // index inside sub-segment
  } sfbp_state_t;

  // one result word
  typedef struct packed {
    logic [7:0] packed_byte;
    logic [3:0] valid_bits;
    logic       frame_done;
  } sfbp_result_t;

  function automatic logic [2:0] lar_width(input logic [2:0] idx);
    logic [2:0] w;
    case (idx)
      3'd0, 3'd1: w = 3'd6;
      3'd2, 3'd3: w = 3'd5;
      3'd4, 3'd5: w = 3'd4;
      default:    w = 3'd3;
    endcase
    return w;
  endfunction

  function automatic logic [2:0] head_width(input logic [1:0] k);
    logic [2:0] w;
    case (k)
      2'd0:    w = 3'd7;   // lag
      2'd1:    w = 3'd2;   // gain
      2'd2:    w = 3'd2;   // grid
      default: w = 3'd6;   // block maximum
    endcase
    return w;
  endfunction

endpackage

// ===== sv/speech_frame_bit_packer_core.sv =====
// speech_frame_bit_packer_core: top level of the GSM full-rate frame bit packer.
// Depends on sfbp_pkg, sfbp_pack, sfbp_outbuf.
//
//   channel | ports                                        | direction
//   --------+----------------------------------------------+----------
//   input   | in_valid, in_ready, in_param_value,          | in
//           | in_end_stream                                |
//   result  | out_valid, out_ready, out_packed_byte,       | out
//           | out_valid_bits, out_frame_done               |
//
// One word per cycle while in_ready is high: the merge of up to seven bits
// into the pending byte is a single shift/OR between the state registers and the
// result register; each result is registered before it shows on out_*.
// Reset (rst_n low, synchronous) clears the accumulator, bit position, frame
// counter and both result slots. A stalled result side is absorbed by one
// skid slot; in_ready drops only while both slots hold an unread byte.
module speech_frame_bit_packer_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [6:0] in_param_value,
  input  logic       in_end_stream,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_packed_byte,
  output logic [3:0] out_valid_bits,
  output logic       out_frame_done
);

  sfbp_pkg::sfbp_state_t  state_r, state_nxt, pack_nxt;
  sfbp_pkg::sfbp_result_t res, out_res;
  logic                   res_valid;
  logic                   in_fire;
  logic                   space;

  assign in_ready = space;
  assign in_fire  = in_valid && in_ready;

  // width lookup, masking, bit merge, byte completion / flush
  sfbp_pack u_pack (
    .state       (state_r),
    .param_value (in_param_value),
    .end_stream  (in_end_stream),
    .state_nxt   (pack_nxt),
    .res_valid   (res_valid),
    .res         (res)
  );

  // packer state only moves on an accepted word
  assign state_nxt = in_fire ? pack_nxt : state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else begin
      state_r <= state_nxt;
    end
  end

  // result register + skid slot
  sfbp_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire && res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign out_packed_byte = out_res.packed_byte;
  assign out_valid_bits  = out_res.valid_bits;
  assign out_frame_done  = out_res.frame_done;

endmodule

// ===== sv/sfbp_pack.sv =====
// sfbp_pack: combinational bit merge and next-state logic for one parameter word.
// Depends on sfbp_pkg.
module sfbp_pack (
  input  sfbp_pkg::sfbp_state_t  state,
  input  logic [6:0]             param_value,
  input  logic                   end_stream,
  output sfbp_pkg::sfbp_state_t  state_nxt,
  output logic                   res_valid,
  output sfbp_pkg::sfbp_result_t res
);

  logic [2:0]  w;
  logic [7:0]  mask;
  logic [7:0]  val;
  logic [14:0] combined;
  logic [3:0]  n;
  logic        done;
  logic        in_lar;

  assign in_lar = (state.fc < 7'(sfbp_pkg::LAR_COUNT));

  always_comb begin
    if (in_lar) begin
      w = sfbp_pkg::lar_width(state.fc[2:0]);
    end else if (state.sub[4:2] == 3'd0) begin
      w = sfbp_pkg::head_width(state.sub[1:0]);
    end else begin
      w = sfbp_pkg::PULSE_WIDTH;
    end
  end

  assign mask     = ~(8'hff << w);
  assign val      = {1'b0, param_value} & mask;
  assign combined = {7'd0, state.acc} | (15'(val) << state.pos);
  assign n        = {1'b0, state.pos} + {1'b0, w};
  assign done     = (state.fc >= sfbp_pkg::LAST_PARAM_IDX);

  always_comb begin
    state_nxt.fc  = done ? 7'd0 : state.fc + 7'd1;
    if (done || in_lar || state.sub == sfbp_pkg::LAST_SUB_IDX) begin
      state_nxt.sub = 5'd0;
    end else begin
      state_nxt.sub = state.sub + 5'd1;
    end

    res_valid       = 1'b0;
    res.frame_done  = done;
    res.packed_byte = combined[7:0];
    res.valid_bits  = sfbp_pkg::FULL_BYTE_BITS;
    state_nxt.acc   = combined[7:0];
    state_nxt.pos   = n[2:0];

    if (n[3]) begin
      // byte completed; leftover bits stay pending even on flush
      res_valid     = 1'b1;
      state_nxt.acc = {1'b0, combined[14:8]};
    end else if (end_stream && n != 4'd0) begin
      res_valid      = 1'b1;
      res.valid_bits = n;
      state_nxt.acc  = 8'd0;
      state_nxt.pos  = 3'd0;
    end
  end

endmodule

// ===== sv/sfbp_outbuf.sv =====
// sfbp_outbuf: two-entry result buffer (output register plus skid slot).
// Depends on sfbp_pkg.
module sfbp_outbuf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  sfbp_pkg::sfbp_result_t push_data,
  output logic                   space,
  output logic                   out_valid,
  input  logic                   out_ready,
  output sfbp_pkg::sfbp_result_t out_data
);

  sfbp_pkg::sfbp_result_t main_r, main_nxt, skid_r, skid_nxt;
  logic main_v_r, main_v_nxt, skid_v_r, skid_v_nxt;
  logic pop;

  assign pop       = main_v_r && out_ready;
  assign space     = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

  always_comb begin
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    if (skid_v_r) begin
      // input is stalled while the skid slot is full
      if (pop) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_v_r || pop) begin
        main_nxt   = push_data;
        main_v_nxt = 1'b1;
      end else begin
        skid_nxt   = push_data;
        skid_v_nxt = 1'b1;
      end
    end else if (pop) begin
      main_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

// ===== sv/sfbp_checker.sv =====
// sfbp_checker: port-level assertions for speech_frame_bit_packer_core, bound in below.
// Depends on speech_frame_bit_packer_core ports only.
module sfbp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [6:0] in_param_value,
  input logic       in_end_stream,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_packed_byte,
  input logic [3:0] out_valid_bits,
  input logic       out_frame_done
);

  // a stalled result word is not dropped and does not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_packed_byte, out_valid_bits, out_frame_done}))
    else $error("result word dropped or changed while stalled");

  // a waiting input word stays put until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_param_value) &&
      $stable(in_end_stream))
    else $error("input word changed while waiting");

  a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_valid_bits != 4'd0 && out_valid_bits <= 4'd8))
    else $error("valid_bits out of range");

  // bits above the filled count of a flushed byte are zero
  a_flush_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_bits != 4'd8 |-> ((out_packed_byte >> out_valid_bits) == 8'd0))
    else $error("unfilled bits not zero");

  // input only backs up behind a pending result
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

endmodule

bind speech_frame_bit_packer_core sfbp_checker u_sfbp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_param_value  (in_param_value),
  .in_end_stream   (in_end_stream),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_packed_byte (out_packed_byte),
  .out_valid_bits  (out_valid_bits),
  .out_frame_done  (out_frame_done)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking testbench for speech_frame_bit_packer_core.
// Depends on sfbp_pkg (constants, result struct) and the packer RTL.
// A bit-exact packing predictor builds the expected byte stream; a monitor checks it.
module tb_top;

  localparam int unsigned RANDOM_WORDS = 1550;
  localparam int unsigned DRAIN_CYCLES = 8;      // quiet spell after the last result
  localparam int unsigned CYCLE_LIMIT  = 200000; // ~1600 words x (gap + slow receiver), x8
  localparam int unsigned PRINT_CAP    = 40;

  // one word on the input channel
  typedef struct {
    logic [6:0] value;
    logic       flush;
  } param_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [6:0] in_param_value = 7'd0;
  logic       in_end_stream = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_packed_byte;
  logic [3:0] out_valid_bits;
  logic       out_frame_done;

  speech_frame_bit_packer_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_param_value (in_param_value),
    .in_end_stream  (in_end_stream),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_packed_byte(out_packed_byte),
    .out_valid_bits (out_valid_bits),
    .out_frame_done (out_frame_done)
  );

  always #5 clk = ~clk;

  param_word_t            param_q[$];      // words waiting to be driven
  sfbp_pkg::sfbp_result_t expected_bytes[$];
  int unsigned            mismatches = 0;
  int unsigned            bytes_seen = 0;
  int unsigned            cycle_count = 0;

  // predictor state: pending bits, fill level, parameter index in frame
  logic [7:0] pk_acc = 8'd0;
  logic [2:0] pk_pos = 3'd0;
  logic [6:0] pk_idx = 7'd0;

  // ---------------------------------------------------------------------------
  // Width schedule: LAR codes 6,6,5,5,4,4,3,3; each sub-segment is
  // lag 7, gain 2, grid 2, block max 6, then thirteen 3-bit pulses.
  // ---------------------------------------------------------------------------
  function automatic int unsigned field_width(input logic [6:0] idx);
    int unsigned k;
    if (idx < sfbp_pkg::LAR_COUNT) begin
      return (idx < 2) ? 6 : (idx < 4) ? 5 : (idx < 6) ? 4 : 3;
    end
    k = (idx - sfbp_pkg::LAR_COUNT) % sfbp_pkg::SUBSEG_LEN;
    case (k)
      0: begin
        return 7;
      end
      1, 2: begin
        return 2;
      end
      3: begin
        return 6;
      end
      default: begin
        return 3;
      end
    endcase
  endfunction

  // Packs one accepted word and queues the byte it produces, if any.
  // A full byte wins over a flush; leftover bits stay pending.
  task automatic pack_param(input logic [6:0] value, input logic flush);
    int unsigned w;
    int unsigned n;
    logic [6:0]  mask;
    logic [15:0] merged;
    logic        frame_end;
    sfbp_pkg::sfbp_result_t r;
    w         = field_width(pk_idx);
    mask      = 7'h7f >> (7 - w);
    merged    = {8'h00, pk_acc} | (16'(value & mask) << pk_pos);
    n         = pk_pos + w;
    frame_end = (pk_idx >= sfbp_pkg::LAST_PARAM_IDX);
    pk_idx    = frame_end ? 7'd0 : pk_idx + 7'd1;
    if (n >= sfbp_pkg::BYTE_BITS) begin
      r.packed_byte = merged[7:0];
      r.valid_bits  = sfbp_pkg::FULL_BYTE_BITS;
      r.frame_done  = frame_end;
      expected_bytes.push_back(r);
      pk_acc = merged[15:8];
      pk_pos = 3'(n - sfbp_pkg::BYTE_BITS);
    end else begin
      pk_acc = merged[7:0];
      pk_pos = 3'(n);
      if (flush && n != 0) begin
        r.packed_byte = pk_acc;
        r.valid_bits  = 4'(n);
        r.frame_done  = frame_end;
        expected_bytes.push_back(r);
        pk_acc = 8'd0;
        pk_pos = 3'd0;
      end
    end
  endtask

  task automatic add_word(input logic [6:0] value, input logic flush);
    param_word_t pw;
    pw.value = value;
    pw.flush = flush;
    param_q.push_back(pw);
  endtask

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("MISMATCH byte %0d: %s", bytes_seen, msg);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length separated by random gaps. The payload
  // only changes when the previous word was taken or valid was low.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;
  param_word_t next_word;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (in_valid && in_ready) begin
        pack_param(in_param_value, in_end_stream);
      end
      if (!(in_valid && !in_ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (param_q.size() > 0) begin
          next_word = param_q.pop_front();
          in_valid       <= 1'b1;
          in_param_value <= next_word.value;
          in_end_stream  <= next_word.flush;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            // about a third of bursts run straight into the next one
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: out_ready follows a rotating 8-bit pattern that is swapped for
  // a new one every so often: always ready, random mix, or mostly stalled.
  // Every pattern has at least one ready bit.
  // ---------------------------------------------------------------------------
  logic [7:0]  ready_pat = 8'hff;
  int unsigned pat_left  = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_pat = 8'hff;
      pat_left  = 0;
    end else begin
      if (pat_left == 0) begin
        case ($urandom_range(0, 3))
          0: begin
            ready_pat = 8'hff;
          end
          1: begin
            ready_pat = 8'h01 << $urandom_range(0, 7);
          end
          default: begin
            ready_pat = 8'($urandom_range(1, 255));
          end
        endcase
        pat_left = $urandom_range(16, 120);
      end
      out_ready <= ready_pat[0];
      ready_pat = {ready_pat[0], ready_pat[7:1]};
      pat_left--;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every accepted result word against the oldest expectation.
  // ---------------------------------------------------------------------------
  sfbp_pkg::sfbp_result_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        report($sformatf("unexpected byte %02h bits %0d frame_done %0b",
                         out_packed_byte, out_valid_bits, out_frame_done));
      end else begin
        want = expected_bytes.pop_front();
        if (out_packed_byte !== want.packed_byte) begin
          report($sformatf("packed_byte %02h, want %02h", out_packed_byte, want.packed_byte));
        end
        if (out_valid_bits !== want.valid_bits) begin
          report($sformatf("valid_bits %0d, want %0d", out_valid_bits, want.valid_bits));
        end
        if (out_frame_done !== want.frame_done) begin
          report($sformatf("frame_done %0b, want %0b", out_frame_done, want.frame_done));
        end
      end
      bytes_seen++;
    end
  end

  // hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned idx;
    logic [6:0]  v;
    logic        f;

    // Directed start of the first frame; positions in comments are the fill
    // level after the word.
    add_word(7'd127,  1'b1); // LAR0 all ones, flushed as a 6-bit partial
    add_word(7'd0,    1'b0); // LAR1 zeros, pos 6
    add_word(7'd127,  1'b1); // LAR2 completes a byte with flush set: byte only, 3 left
    add_word(7'h55,   1'b0); // LAR3 lands exactly on a byte boundary
    add_word(7'h0f,   1'b1); // LAR4 4-bit partial
    add_word(7'h70,   1'b0); // LAR5 upper bits must be dropped
    add_word(7'd7,    1'b0); // LAR6 pos 7
    add_word(7'd1,    1'b1); // LAR7 byte plus flush, 2 bits stay pending
    add_word(7'd127,  1'b0); // lag, full 7 bits
    add_word(7'h7e,   1'b0); // gain, only low 2 bits
    add_word(7'd1,    1'b0); // grid
    add_word(7'h3f,   1'b0); // block max
    add_word(7'd0,    1'b0); // pulses from here
    add_word(7'd7,    1'b0);
    add_word(7'h78,   1'b0);
    add_word(7'd5,    1'b0);
    add_word(7'd2,    1'b0);
    add_word(7'd127,  1'b0);
    add_word(7'h7c,   1'b1); // exact byte with flush: nothing left to flush
    add_word(7'd3,    1'b0);
    add_word(7'd6,    1'b0);
    add_word(7'd0,    1'b0);
    add_word(7'd127,  1'b1); // 4-bit partial in a pulse run
    add_word(7'd1,    1'b0);
    add_word(7'd4,    1'b0);

    // Random part keeps frame order; flush is rare except at frame end,
    // where it is a coin toss so both frame-end outcomes show up.
    for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
      idx = (25 + i) % sfbp_pkg::FRAME_PARAMS;
      case ($urandom_range(0, 7))
        0: begin
          v = 7'd0;
        end
        1: begin
          v = 7'd127;
        end
        default: begin
          v = 7'($urandom_range(0, 127));
        end
      endcase
      f = (idx == sfbp_pkg::FRAME_PARAMS - 1) ? 1'($urandom_range(0, 1))
                                              : ($urandom_range(0, 15) == 0);
      add_word(v, f);
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // all words accepted, all bytes back, then a short quiet spell
    while (param_q.size() != 0 || in_valid) begin
      @(posedge clk);
    end
    while (expected_bytes.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== speech_frame_bit_packer_core.f =====
sv/sfbp_pkg.sv
sv/sfbp_pack.sv
sv/sfbp_outbuf.sv
sv/speech_frame_bit_packer_core.sv
sv/sfbp_checker.sv
tb/tb_top.sv
